// ===== design/esd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// shared constants, types and the month length table for the epoch seconds
// to calendar date converter
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int unsigned SecWidth     = 32;
    localparam int unsigned RemWidth     = 11;
    localparam int unsigned CntWidth     = 6;
    localparam int unsigned DayWidth     = 16;

    localparam logic [RemWidth-1:0] SecsPerMin   = 11'd60;
    localparam logic [RemWidth-1:0] MinsPerHour  = 11'd60;
    localparam logic [RemWidth-1:0] HoursPerDay  = 11'd24;
    localparam logic [RemWidth-1:0] DaysQuad     = 11'd1461;
    localparam logic [RemWidth-1:0] DaysLeap     = 11'd366;
    localparam logic [RemWidth-1:0] DaysCommon   = 11'd365;

    localparam logic [DayWidth-1:0] DayOf2000    = 16'd10957;
    localparam logic [DayWidth-1:0] DayOf2100    = 16'd47482;

    localparam logic [CntWidth-1:0] StepsSec     = 6'd32;
    localparam logic [CntWidth-1:0] StepsMin     = 6'd27;
    localparam logic [CntWidth-1:0] StepsHour    = 6'd21;
    localparam logic [CntWidth-1:0] StepsQuad    = 6'd16;

    localparam logic [3:0] LastMonth = 4'd11;

    typedef struct packed {
        logic                start;
        logic [RemWidth-1:0] divisor;
        logic [CntWidth-1:0] steps;
    } div_cmd_t;

    function automatic logic [RemWidth-1:0] month_days(input logic [3:0] m, input logic leap);
        logic [RemWidth-1:0] len;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 11'd31;
            4'd1:                                       len = leap ? 11'd29 : 11'd28;
            default:                                    len = 11'd30;
        endcase
        return len;
    endfunction

endpackage

// ===== design/epoch_seconds_to_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// converts a 32-bit count of seconds since 1970-01-01 into time of day and a
// calendar date for the years 2000 to 2099
// ----------------------------------------------------------------------------
// One transaction is converted at a time. A shared one-bit-per-cycle divider
// runs three divisions in turn (32, 27 and 21 quotient bits) for seconds,
// minutes and hours; for dates inside 2000..2099 a fourth (16 quotient bits)
// splits the days into four-year blocks, followed by year steps and then
// month steps. The next input transaction is taken as soon as the result has
// moved into the output register, even while that result is still stalled.
module epoch_seconds_to_date
    import esd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SecWidth-1:0] epoch_seconds,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [6:0]          year_offset,
    output logic [3:0]          month_number,
    output logic [4:0]          day_of_month,
    output logic [4:0]          hour_value,
    output logic [5:0]          minute_value,
    output logic [5:0]          second_value,
    output logic                out_of_range
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_DIV_MIN,
        ST_DIV_HOUR,
        ST_RANGE,
        ST_DIV_QUAD,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    div_cmd_t            cmd_reg, cmd_next;
    logic [SecWidth-1:0] dvd_reg, dvd_next;
    logic [5:0]          sec_reg, sec_next;
    logic [5:0]          min_reg, min_next;
    logic [4:0]          hour_reg, hour_next;
    logic [DayWidth-1:0] days_reg, days_next;
    logic [4:0]          quad_reg, quad_next;
    logic [1:0]          yq_reg, yq_next;
    logic [RemWidth-1:0] doy_reg, doy_next;
    logic                leap_reg, leap_next;
    logic [3:0]          mon_reg, mon_next;
    logic                oor_reg, oor_next;
    logic                ovalid_reg, ovalid_next;
    logic [6:0]          oyear_reg, oyear_next;
    logic [3:0]          omon_reg, omon_next;
    logic [4:0]          oday_reg, oday_next;
    logic [4:0]          ohour_reg, ohour_next;
    logic [5:0]          omin_reg, omin_next;
    logic [5:0]          osec_reg, osec_next;
    logic                ooor_reg, ooor_next;

    logic                div_done;
    logic [SecWidth-1:0] div_quo;
    logic [RemWidth-1:0] div_rem;
    logic [DayWidth-1:0] day_rel;
    logic [RemWidth-1:0] mlen;

    esd_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_reg),
        .dividend  (dvd_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        day_rel = days_reg - DayOf2000;
        mlen    = month_days(mon_reg, leap_reg);

        state_next  = state_reg;
        cmd_next    = '0;
        cmd_next.divisor = cmd_reg.divisor;
        cmd_next.steps   = cmd_reg.steps;
        dvd_next    = dvd_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        days_next   = days_reg;
        quad_next   = quad_reg;
        yq_next     = yq_reg;
        doy_next    = doy_reg;
        leap_next   = leap_reg;
        mon_next    = mon_reg;
        oor_next    = oor_reg;
        ovalid_next = ovalid_reg && out_stall;
        oyear_next  = oyear_reg;
        omon_next   = omon_reg;
        oday_next   = oday_reg;
        ohour_next  = ohour_reg;
        omin_next   = omin_reg;
        osec_next   = osec_reg;
        ooor_next   = ooor_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = '{start: 1'b1, divisor: SecsPerMin, steps: StepsSec};
                    dvd_next   = epoch_seconds;
                    state_next = ST_DIV_SEC;
                end
            end
            ST_DIV_SEC:
            begin
                if (div_done)
                begin
                    sec_next   = div_rem[5:0];
                    cmd_next   = '{start: 1'b1, divisor: MinsPerHour, steps: StepsMin};
                    dvd_next   = {div_quo[26:0], 5'd0};
                    state_next = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                if (div_done)
                begin
                    min_next   = div_rem[5:0];
                    cmd_next   = '{start: 1'b1, divisor: HoursPerDay, steps: StepsHour};
                    dvd_next   = {div_quo[20:0], 11'd0};
                    state_next = ST_DIV_HOUR;
                end
            end
            ST_DIV_HOUR:
            begin
                if (div_done)
                begin
                    hour_next  = div_rem[4:0];
                    days_next  = div_quo[DayWidth-1:0];
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                if (days_reg < DayOf2000 || days_reg >= DayOf2100)
                begin
                    oor_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    oor_next   = 1'b0;
                    cmd_next   = '{start: 1'b1, divisor: DaysQuad, steps: StepsQuad};
                    dvd_next   = {day_rel, 16'd0};
                    state_next = ST_DIV_QUAD;
                end
            end
            ST_DIV_QUAD:
            begin
                if (div_done)
                begin
                    quad_next  = div_quo[4:0];
                    doy_next   = div_rem;
                    yq_next    = 2'd0;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                mon_next = 4'd0;
                if (yq_reg == 2'd0)
                begin
                    if (doy_reg < DaysLeap)
                    begin
                        leap_next  = 1'b1;
                        state_next = ST_MONTH;
                    end
                    else
                    begin
                        doy_next = doy_reg - DaysLeap;
                        yq_next  = 2'd1;
                    end
                end
                else if (doy_reg >= DaysCommon)
                begin
                    doy_next = doy_reg - DaysCommon;
                    yq_next  = yq_reg + 2'd1;
                end
                else
                begin
                    leap_next  = 1'b0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (doy_reg < mlen || mon_reg == LastMonth)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    doy_next = doy_reg - mlen;
                    mon_next = mon_reg + 4'd1;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    ohour_next  = hour_reg;
                    omin_next   = min_reg;
                    osec_next   = sec_reg;
                    ooor_next   = oor_reg;
                    if (oor_reg)
                    begin
                        oyear_next = 7'd0;
                        omon_next  = 4'd0;
                        oday_next  = 5'd0;
                    end
                    else
                    begin
                        oyear_next = {quad_reg, yq_reg};
                        omon_next  = mon_reg + 4'd1;
                        oday_next  = doy_reg[4:0] + 5'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hour_reg  <= hour_next;
        days_reg  <= days_next;
        quad_reg  <= quad_next;
        yq_reg    <= yq_next;
        doy_reg   <= doy_next;
        leap_reg  <= leap_next;
        mon_reg   <= mon_next;
        oor_reg   <= oor_next;
        oyear_reg <= oyear_next;
        omon_reg  <= omon_next;
        oday_reg  <= oday_next;
        ohour_reg <= ohour_next;
        omin_reg  <= omin_next;
        osec_reg  <= osec_next;
        ooor_reg  <= ooor_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = ovalid_reg;
    assign year_offset  = oyear_reg;
    assign month_number = omon_reg;
    assign day_of_month = oday_reg;
    assign hour_value   = ohour_reg;
    assign minute_value = omin_reg;
    assign second_value = osec_reg;
    assign out_of_range = ooor_reg;

endmodule

// ===== design/esd_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_serial_div
// restoring divider that retires one quotient bit per cycle from a
// left-aligned dividend by a narrow constant divisor
// ----------------------------------------------------------------------------
module esd_serial_div
    import esd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_cmd_t            cmd,
    input  logic [SecWidth-1:0] dividend,
    output logic                done,
    output logic [SecWidth-1:0] quotient,
    output logic [RemWidth-1:0] remainder
);

    logic [SecWidth-1:0] num_reg, num_next;
    logic [SecWidth-1:0] quo_reg, quo_next;
    logic [RemWidth-1:0] rem_reg, rem_next;
    logic [RemWidth-1:0] dvs_reg, dvs_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [RemWidth:0]   trial;
    logic [RemWidth:0]   diff;
    logic                ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[SecWidth-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});

        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            dvs_next = cmd.divisor;
            cnt_next = cmd.steps;
        end
        else if (cnt_reg != '0)
        begin
            num_next  = {num_reg[SecWidth-2:0], 1'b0};
            quo_next  = {quo_reg[SecWidth-2:0], ge};
            rem_next  = ge ? diff[RemWidth-1:0] : trial[RemWidth-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== tb/sv/tb_epoch_seconds_to_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_date
// self-checking bench for the seconds to calendar date converter: every
// accepted count of seconds is converted by a behavioral date calculation and
// compared field by field with the result that leaves the block, under random
// idling on both sides, a long output hold-off and a quiet final stretch
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_date;
    import esd_pkg::*;

    localparam int unsigned HalfPeriod    = 10;
    localparam int unsigned ResetCycles   = 12;
    localparam int unsigned DaySecs       = 86400;
    localparam int unsigned Y2kSecs       = 946684800;
    localparam int unsigned Y2kDay        = 10957;
    localparam int unsigned Y2100Day      = 47482;
    localparam int unsigned CenturyDays   = 36525;
    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned LongHold      = 500;
    localparam int unsigned DrainCycles   = 200;
    localparam int unsigned MaxReports    = 10;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       oor;
    } date_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SecWidth-1:0] epoch_seconds;
    logic                out_valid;
    logic                out_stall;
    logic [6:0]          year_offset;
    logic [3:0]          month_number;
    logic [4:0]          day_of_month;
    logic [4:0]          hour_value;
    logic [5:0]          minute_value;
    logic [5:0]          second_value;
    logic                out_of_range;

    date_t               pending_dates[$];
    logic [31:0]         pending_seconds[$];
    int unsigned         mismatch_count = 0;
    bit                  gaps_on = 1'b1;
    bit                  stalls_on = 1'b1;
    bit                  hold_request = 1'b0;

    epoch_seconds_to_date dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .epoch_seconds(epoch_seconds),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .year_offset  (year_offset),
        .month_number (month_number),
        .day_of_month (day_of_month),
        .hour_value   (hour_value),
        .minute_value (minute_value),
        .second_value (second_value),
        .out_of_range (out_of_range)
    );

    always #(HalfPeriod) clk = ~clk;

    function automatic int unsigned month_length(int unsigned m, bit leap);
        case (m)
            1:           return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic date_t predict_date(logic [31:0] s);
        date_t       r;
        int unsigned t;
        int unsigned days;
        int unsigned d;
        int unsigned rem4;
        int unsigned year;
        int unsigned doy;
        int unsigned m;
        bit          leap;
        r = '0;
        r.second = 6'(s % 60);
        t = s / 60;
        r.minute = 6'(t % 60);
        t = t / 60;
        r.hour = 5'(t % 24);
        days = t / 24;
        if (days < Y2kDay || days >= Y2100Day)
        begin
            r.oor = 1'b1;
        end
        else
        begin
            d = days - Y2kDay;
            rem4 = d % 1461;
            leap = rem4 < 366;
            if (leap)
            begin
                year = (d / 1461) * 4;
                doy = rem4;
            end
            else
            begin
                year = (d / 1461) * 4 + 1 + (rem4 - 366) / 365;
                doy = (rem4 - 366) % 365;
            end
            m = 0;
            while (m < 11 && doy >= month_length(m, leap))
            begin
                doy = doy - month_length(m, leap);
                m++;
            end
            r.year = 7'(year);
            r.month = 4'(m + 1);
            r.mday = 5'(doy + 1);
        end
        return r;
    endfunction

    // day counts from 2000-01-01
    function automatic logic [31:0] at_day(int unsigned day, int unsigned sod);
        logic [63:0] secs;
        secs = 64'(Y2kSecs) + 64'(day) * 64'(DaySecs) + 64'(sod);
        return secs[31:0];
    endfunction

    // random time with bias toward month, year and midnight boundaries
    function automatic logic [31:0] calendar_time();
        int unsigned y;
        int unsigned m;
        int unsigned k;
        int unsigned day;
        int unsigned len;
        int unsigned sod;
        y = $urandom_range(0, 99);
        m = $urandom_range(0, 11);
        day = y * 365 + (y + 3) / 4;
        for (k = 0; k < m; k++)
            day = day + month_length(k, y % 4 == 0);
        len = month_length(m, y % 4 == 0);
        case ($urandom_range(0, 2))
            0:       day = day;
            1:       day = day + len - 1;
            default: day = day + $urandom_range(0, len - 1);
        endcase
        case ($urandom_range(0, 2))
            0:       sod = 0;
            1:       sod = DaySecs - 1;
            default: sod = $urandom_range(0, DaySecs - 1);
        endcase
        return at_day(day, sod);
    endfunction

    task automatic send_time(input logic [31:0] s);
        int unsigned n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        epoch_seconds <= s;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic test_range_edges();
        send_time(32'h0000_0000);
        send_time(32'hFFFF_FFFF);
        send_time(at_day(0, 0) - 32'd1);
        send_time(at_day(0, 0));
        send_time(at_day(CenturyDays - 1, DaySecs - 1));
        send_time(at_day(CenturyDays, 0));
        send_time(at_day(CenturyDays, 45296));
    endtask

    task automatic test_leap_days();
        send_time(at_day(58, DaySecs - 1));
        send_time(at_day(59, 0));
        send_time(at_day(59, DaySecs - 1));
        send_time(at_day(60, 0));
        send_time(at_day(364, 3723));
        send_time(at_day(365, DaySecs - 1));
        send_time(at_day(366, 0));
        send_time(at_day(424, 43200));
        send_time(at_day(425, 0));
        send_time(at_day(1826, 86340));
        send_time(at_day(35123, 59));
        send_time(at_day(35429, DaySecs - 1));
    endtask

    // output held off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        int unsigned i;
        hold_request = 1'b1;
        for (i = 0; i < 6; i++)
            send_time(calendar_time());
    endtask

    task automatic test_random_dates(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_time(calendar_time());
                5, 6, 7:       send_time($urandom_range(Y2kSecs, 32'hF486_8FFF));
                default:       send_time($urandom);
            endcase
        end
    endtask

    task automatic test_quiet_tail(input int unsigned count);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        test_random_dates(count);
    endtask

    initial
    begin : receiver
        int unsigned n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LongHold) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : conversion_check
        date_t       want;
        date_t       got;
        logic [31:0] secs;
        if (rst_n && in_valid && !in_stall)
        begin
            pending_dates.push_back(predict_date(epoch_seconds));
            pending_seconds.push_back(epoch_seconds);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.year = year_offset;
            got.month = month_number;
            got.mday = day_of_month;
            got.hour = hour_value;
            got.minute = minute_value;
            got.second = second_value;
            got.oor = out_of_range;
            if (pending_dates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MaxReports)
                    $display("unexpected result transaction: %p", got);
            end
            else
            begin
                want = pending_dates.pop_front();
                secs = pending_seconds.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports)
                        $display("mismatch for %0d s: expected %p, got %p", secs, want, got);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no transaction for %0d cycles", WatchdogLimit);
        $display("tb_epoch_seconds_to_date: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        epoch_seconds <= '0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_range_edges();
        test_leap_days();
        test_backpressure();
        test_random_dates(1300);
        test_quiet_tail(180);
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("tb_epoch_seconds_to_date: PASS");
        else
            $display("tb_epoch_seconds_to_date: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/esd_pkg.sv
design/esd_serial_div.sv
design/epoch_seconds_to_date.sv
tb/sv/tb_epoch_seconds_to_date.sv
